/* sv/itoaf_pkg.sv */
// ----------------------------------------------------------------------------
// itoaf_pkg: shared types and constants for the integer-to-ASCII formatter
// Conversion codes, pad codes, ASCII constants and the front-to-back job word.
// ----------------------------------------------------------------------------
package itoaf_pkg;

    // Conversion codes on s_cmd
    localparam logic [1:0] CMD_SDEC = 2'd0;
    localparam logic [1:0] CMD_UDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;
    localparam logic [1:0] CMD_PTR  = 2'd3;

    // Pad codes on s_pad_mode (the unused code pads with spaces)
    localparam logic [1:0] PAD_SPACE = 2'd0;
    localparam logic [1:0] PAD_ZERO  = 2'd1;
    localparam logic [1:0] PAD_DASH  = 2'd2;

    localparam int MAX_WIDTH_DEF = 32;

    localparam int VALUE_W   = 64;
    localparam int FWIDTH_W  = 6;
    localparam int CHAR_W    = 7;
    localparam int DIGITS    = 20;          // decimal digits of a 64-bit value
    localparam int DIGIT_W   = 4;
    localparam int BCD_W     = DIGITS * DIGIT_W;
    localparam int ND_W      = $clog2(DIGITS + 1);
    localparam int FIFO_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX
    } prefix_t;

    // One classified conversion, handed from front to back
    typedef struct packed {
        logic [VALUE_W-1:0]  mag;     // magnitude to print
        logic                hex;     // base 16 when set, else base 10
        prefix_t             prefix;
        logic [CHAR_W-1:0]   pad_char;
        logic [FWIDTH_W-1:0] width;   // already saturated
    } job_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'ha: c = 7'h61;
            4'hb: c = 7'h62;
            4'hc: c = 7'h63;
            4'hd: c = 7'h64;
            4'he: c = 7'h65;
            default: c = 7'h66;
        endcase
        return c;
    endfunction

endpackage

/* sv/itoaf_front.sv */
// ----------------------------------------------------------------------------
// itoaf_front: request classifier
// Extends operand, takes magnitude, picks base, prefix, pad char, caps width.
// ----------------------------------------------------------------------------
module itoaf_front import itoaf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic [1:0]          s_cmd,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic                s_operand_size,
    input  logic [FWIDTH_W-1:0] s_field_width,
    input  logic [1:0]          s_pad_mode,
    output job_t                job
);

    localparam logic [FWIDTH_W-1:0] WMAX = FWIDTH_W'(MAX_WIDTH);

    logic [VALUE_W-1:0] ext;
    logic               neg;

    always_comb begin
        if (s_operand_size) begin
            ext = s_value;
        end else if (s_cmd == CMD_SDEC) begin
            ext = {{32{s_value[31]}}, s_value[31:0]};
        end else begin
            ext = {32'b0, s_value[31:0]};
        end
    end

    assign neg = (s_cmd == CMD_SDEC) && ext[VALUE_W-1];

    always_comb begin
        job.mag = neg ? (VALUE_W'(0) - ext) : ext;
        job.hex = (s_cmd == CMD_HEX) || (s_cmd == CMD_PTR);
        if (neg) begin
            job.prefix = PFX_MINUS;
        end else if (s_cmd == CMD_PTR) begin
            job.prefix = PFX_HEX;
        end else begin
            job.prefix = PFX_NONE;
        end
        case (s_pad_mode)
            PAD_ZERO: job.pad_char = CH_ZERO;
            PAD_DASH: job.pad_char = CH_DASH;
            default:  job.pad_char = CH_SPACE;
        endcase
        job.width = (s_field_width > WMAX) ? WMAX : s_field_width;
    end

endmodule

/* sv/itoaf_fifo.sv */
// ----------------------------------------------------------------------------
// itoaf_fifo: job queue
// Short queue between the classifier and the digit engine.
// ----------------------------------------------------------------------------
module itoaf_fifo import itoaf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    job_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

/* sv/itoaf_back.sv */
// ----------------------------------------------------------------------------
// itoaf_back: digit engine and character emitter
// Binary-to-BCD (decimal only) by shift-and-add-3, digit scan, one char a cycle unless stalled.
// ----------------------------------------------------------------------------
module itoaf_back import itoaf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  job_t                q_job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_out_char,
    output logic                m_last
);

    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int IDX_W         = $clog2(DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PFX,
        ST_X,
        ST_PAD,
        ST_DIGIT
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [VALUE_W-1:0]  sh_reg;
    logic [BCD_W-1:0]    dig_reg;
    prefix_t             prefix_reg;
    logic [CHAR_W-1:0]   pad_char_reg;
    logic [FWIDTH_W-1:0] width_reg;
    logic [FWIDTH_W-1:0] pad_cnt_reg;
    logic [ND_W-1:0]     dcnt_reg;
    logic                m_valid_reg;
    logic [CHAR_W-1:0]   m_out_char_reg;
    logic                m_last_reg;

    logic [VALUE_W-1:0]  sh_next;
    logic [BCD_W-1:0]    bcd_next;
    logic [ND_W-1:0]     nd_next;
    logic [FWIDTH_W-1:0] pad_next;
    logic [IDX_W-1:0]    dig_idx;
    logic                out_free;
    logic                load_char;

    assign q_ready    = (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_ready;
    assign load_char  = out_free && (state_reg inside {ST_PFX, ST_X, ST_PAD, ST_DIGIT});
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last     = m_last_reg;
    assign dig_idx    = IDX_W'(dcnt_reg - 1'b1);

    // four shift-and-add-3 steps per cycle
    always_comb begin
        bcd_next = dig_reg;
        sh_next  = sh_reg;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd_next[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                    bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], sh_next[VALUE_W-1]};
            sh_next  = {sh_next[VALUE_W-2:0], 1'b0};
        end
    end

    // significant digit count (zero still prints one digit) and pad count
    always_comb begin
        nd_next = ND_W'(1);
        for (int d = 0; d < DIGITS; d++) begin
            if (dig_reg[d*DIGIT_W +: DIGIT_W] != '0) begin
                nd_next = ND_W'(d + 1);
            end
        end
        pad_next = (width_reg > FWIDTH_W'(nd_next)) ? width_reg - FWIDTH_W'(nd_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_char) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        prefix_reg   <= q_job.prefix;
                        pad_char_reg <= q_job.pad_char;
                        width_reg    <= q_job.width;
                        sh_reg       <= q_job.mag;
                        step_reg     <= '0;
                        if (q_job.hex) begin
                            dig_reg   <= {(BCD_W - VALUE_W)'(0), q_job.mag};
                            state_reg <= ST_SCAN;
                        end else begin
                            dig_reg   <= '0;
                            state_reg <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    dig_reg  <= bcd_next;
                    sh_reg   <= sh_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CONV_STEPS - 1)) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    dcnt_reg    <= nd_next;
                    pad_cnt_reg <= pad_next;
                    if (prefix_reg != PFX_NONE) begin
                        state_reg <= ST_PFX;
                    end else if (pad_next != '0) begin
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_DIGIT;
                    end
                end
                ST_PFX: begin
                    if (out_free) begin
                        m_last_reg     <= 1'b0;
                        m_out_char_reg <= (prefix_reg == PFX_MINUS) ? CH_DASH : CH_ZERO;
                        if (prefix_reg == PFX_HEX) begin
                            state_reg <= ST_X;
                        end else if (pad_cnt_reg != '0) begin
                            state_reg <= ST_PAD;
                        end else begin
                            state_reg <= ST_DIGIT;
                        end
                    end
                end
                ST_X: begin
                    if (out_free) begin
                        m_last_reg     <= 1'b0;
                        m_out_char_reg <= CH_X;
                        state_reg      <= (pad_cnt_reg != '0) ? ST_PAD : ST_DIGIT;
                    end
                end
                ST_PAD: begin
                    if (out_free) begin
                        m_last_reg     <= 1'b0;
                        m_out_char_reg <= pad_char_reg;
                        pad_cnt_reg    <= pad_cnt_reg - 1'b1;
                        if (pad_cnt_reg == FWIDTH_W'(1)) begin
                            state_reg <= ST_DIGIT;
                        end
                    end
                end
                ST_DIGIT: begin
                    if (out_free) begin
                        m_last_reg     <= (dcnt_reg == ND_W'(1));
                        m_out_char_reg <= digit_char(dig_reg[dig_idx*DIGIT_W +: DIGIT_W]);
                        dcnt_reg       <= dcnt_reg - 1'b1;
                        if (dcnt_reg == ND_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/integer_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf-style %d / %u / %x / %p conversion
// Turns one integer conversion request into a run of ASCII characters.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel is one conversion; it comes back on the m_
// channel as a run of 7-bit ASCII characters, most significant digit first,
// with m_last set on the final one. Signed decimal with a negative value
// prints '-' then the magnitude; pointer prints "0x" then lower-case hex.
// Pad characters (space, '0' or '-') sit between any prefix and the digits so
// that pad and digits together fill s_field_width, which saturates at
// MAX_WIDTH. Digits longer than the width are never cut. The back end picks
// up a job when idle and converts decimal values from binary to BCD (4 bits
// per cycle through the shift-and-add-3 loop; hex skips this step). It then
// counts digits and emits prefix + max(width, digits) characters, one per
// cycle while the output is not stalled. A new job is taken only when idle.
// A two-entry job queue lets the front accept new requests while the back is
// still emitting, so s_ready stays high until two jobs are waiting.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import itoaf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic                s_operand_size,
    input  logic [FWIDTH_W-1:0] s_field_width,
    input  logic [1:0]          s_pad_mode,
    // character channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_out_char,
    output logic                m_last
);

    job_t front_job;   // classified request, straight from the ports
    job_t q_job;       // head of the job queue
    logic q_valid;
    logic q_ready;

    // front: sign handling, magnitude, base, prefix and pad selection
    itoaf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .s_cmd          (s_cmd),
        .s_value        (s_value),
        .s_operand_size (s_operand_size),
        .s_field_width  (s_field_width),
        .s_pad_mode     (s_pad_mode),
        .job            (front_job)
    );

    // queue: a request is taken whenever a slot is free
    itoaf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_job    (front_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    // back: digit generation and registered character output
    itoaf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_job      (q_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

/* sv/itoaf_checker.sv */
// ----------------------------------------------------------------------------
// itoaf_checker: port-level checks for the formatter
// Output hold under stall, legal character set, runs end on a digit.
// ----------------------------------------------------------------------------
module itoaf_checker import itoaf_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAR_W-1:0] m_out_char,
    input logic              m_last
);

    logic is_digit;
    logic is_legal;

    assign is_digit = ((m_out_char >= 7'h30) && (m_out_char <= 7'h39)) ||
                      ((m_out_char >= 7'h61) && (m_out_char <= 7'h66));
    assign is_legal = is_digit || (m_out_char == CH_SPACE) ||
                      (m_out_char == CH_DASH) || (m_out_char == CH_X);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last))
        else $error("stalled character changed");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> is_legal)
        else $error("character outside the formatter alphabet");

    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> is_digit)
        else $error("run ends on a non-digit");

endmodule

bind integer_to_ascii_formatter itoaf_checker u_itoaf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_char (m_out_char),
    .m_last     (m_last)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_to_ascii_formatter
// Sends conversion requests and predicts the ASCII run that each one yields.
// The predictor keeps a queue of the characters still due. A checker compares
// every character transfer against the head of that queue. Stimulus runs in
// phases: directed corner cases, random requests with random gaps and output
// stalls, a long output hold-off that backs the block up, and a gap-free tail.
// ----------------------------------------------------------------------------
module tb;
    import itoaf_pkg::*;

    localparam int      MAX_FIELD       = MAX_WIDTH_DEF;
    localparam int      QUIET_LIMIT     = 4000;  // cycles with no transfer on either side
    localparam int      HOLD_OFF_CYCLES = 150;   // long output stall in the pressure phase
    localparam int      SETTLE_CYCLES   = 60;    // settle time before the final verdict
    localparam logic [1:0]        PAD_UNUSED = 2'd3;  // spare pad code, pads with spaces
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

    // One predicted character transfer on the m_ channel
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_cmd;
    logic [VALUE_W-1:0]  s_value;
    logic                s_operand_size;
    logic [FWIDTH_W-1:0] s_field_width;
    logic [1:0]          s_pad_mode;
    logic                m_valid;
    logic                m_ready;
    logic [CHAR_W-1:0]   m_out_char;
    logic                m_last;

    char_beat_t expected_chars[$];   // characters still owed by the block, oldest first
    int         mismatch_count = 0;
    int         chars_seen     = 0;
    int         quiet_cycles   = 0;
    bit         source_gaps    = 0;  // sender inserts idle bursts
    bit         sink_stalls    = 0;  // receiver drops m_ready in bursts
    bit         hold_request   = 0;  // one-shot: receiver holds off for HOLD_OFF_CYCLES

    integer_to_ascii_formatter #(
        .MAX_WIDTH(MAX_FIELD)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_value       (s_value),
        .s_operand_size(s_operand_size),
        .s_field_width (s_field_width),
        .s_pad_mode    (s_pad_mode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: builds the character run for one request and queues it.
    // Order of a run: optional '-' or "0x", pad chars, then digits MSB first.
    // ------------------------------------------------------------------------
    function automatic void predict_chars(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                                          input logic wide, input logic [FWIDTH_W-1:0] fw,
                                          input logic [1:0] pad);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [3:0]         d;
        logic [CHAR_W-1:0]  pad_char;
        logic [CHAR_W-1:0]  digit_run[$];
        logic [CHAR_W-1:0]  run[$];
        int                 width;
        char_beat_t         beat;

        width    = (fw > MAX_FIELD) ? MAX_FIELD : int'(fw);
        pad_char = (pad == PAD_ZERO) ? CH_ZERO : (pad == PAD_DASH) ? CH_DASH : CH_SPACE;

        // 32-bit operands: sign-extend only for signed decimal
        mag = value;
        if (!wide) begin
            mag = {32'd0, value[31:0]};
            if (cmd == CMD_SDEC && value[31])
                mag[63:32] = '1;
        end

        if (cmd == CMD_SDEC && mag[63]) begin
            run.push_back(CH_DASH);
            mag = -mag;   // wraps correctly for the most negative value
        end
        if (cmd == CMD_PTR) begin
            run.push_back(CH_ZERO);
            run.push_back(CH_X);
        end

        radix = (cmd == CMD_HEX || cmd == CMD_PTR) ? 64'd16 : 64'd10;
        do begin
            d = 4'(mag % radix);
            digit_run.push_front((d < 4'd10) ? CH_ZERO + CHAR_W'(d)
                                             : CH_LOWER_A + CHAR_W'(d) - CHAR_W'(10));
            mag = mag / radix;
        end while (mag != 0);

        for (int k = digit_run.size(); k < width; k++)
            run.push_back(pad_char);
        foreach (digit_run[k])
            run.push_back(digit_run[k]);

        foreach (run[k]) begin
            beat.ch   = run[k];
            beat.last = (k == run.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch at char %0d: %s", $time, chars_seen, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request sender. Called right after a rising edge; returns at the edge
    // where the transfer took place, with s_valid still high so a following
    // call can present the next request back to back without a bubble.
    // ------------------------------------------------------------------------
    task automatic offer_conversion(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                                    input logic wide, input logic [FWIDTH_W-1:0] fw,
                                    input logic [1:0] pad);
        int gap;
        gap = (source_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_value        <= value;
        s_operand_size <= wide;
        s_field_width  <= fw;
        s_pad_mode     <= pad;
        do
            @(posedge aclk);
        while (!s_ready);
        predict_chars(cmd, value, wide, fw, pad);
    endtask

    // Sender goes quiet until every queued character has come back
    task automatic drain_outstanding();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: m_ready in random stall bursts, or one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : sink_ready
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every character transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : char_checker
        char_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected char 0x%02h last=%0b", m_out_char, m_last));
            end else begin
                want = expected_chars.pop_front();
                if (m_out_char !== want.ch)
                    flag_mismatch($sformatf("char 0x%02h, want 0x%02h", m_out_char, want.ch));
                if (m_last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
            end
            chars_seen++;
        end
    end

    // Watchdog: a hung handshake on either side ends the run
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test phases
    // ------------------------------------------------------------------------

    // Corner cases: zero, sign handling at both operand sizes, most negative
    // values, junk in the upper half of 32-bit operands, every pad code,
    // width saturation, and digit runs longer than the field.
    task automatic test_directed();
        offer_conversion(CMD_SDEC, 64'd0, 1'b0, 6'd0, PAD_SPACE);
        offer_conversion(CMD_UDEC, 64'd0, 1'b1, 6'd1, PAD_ZERO);
        offer_conversion(CMD_HEX,  64'd0, 1'b1, 6'd4, PAD_DASH);
        offer_conversion(CMD_PTR,  64'd0, 1'b0, 6'd8, PAD_ZERO);
        offer_conversion(CMD_SDEC, 64'h1234_5678_FFFF_FFFF, 1'b0, 6'd0, PAD_SPACE);
        offer_conversion(CMD_SDEC, 64'hFFFF_FFFF_8000_0000, 1'b0, 6'd12, PAD_ZERO);
        offer_conversion(CMD_SDEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, PAD_SPACE);
        offer_conversion(CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd25, PAD_DASH);
        offer_conversion(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd5, PAD_ZERO);
        offer_conversion(CMD_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0, 6'd3, PAD_SPACE);
        offer_conversion(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd5, PAD_SPACE);
        offer_conversion(CMD_UDEC, 64'hDEAD_BEEF_FFFF_FFFF, 1'b0, 6'd32, PAD_ZERO);
        offer_conversion(CMD_UDEC, 64'd10000000000000000000, 1'b1, 6'd21, PAD_DASH);
        offer_conversion(CMD_HEX,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0, PAD_SPACE);
        offer_conversion(CMD_HEX,  64'h0123_4567_89AB_CDEF, 1'b1, 6'd63, PAD_ZERO);
        offer_conversion(CMD_HEX,  64'hFEDC_BA98_7654_3210, 1'b0, 6'd33, PAD_SPACE);
        offer_conversion(CMD_PTR,  64'hCAFE_F00D_8000_0000, 1'b0, 6'd0, PAD_SPACE);
        offer_conversion(CMD_PTR,  64'hFEDC_BA98_7654_3210, 1'b1, 6'd20, PAD_DASH);
        offer_conversion(CMD_UDEC, 64'd42, 1'b1, 6'd10, PAD_UNUSED);
        offer_conversion(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 6'd63, PAD_UNUSED);
        offer_conversion(CMD_PTR,  64'd1, 1'b1, 6'd32, PAD_ZERO);
        offer_conversion(CMD_UDEC, 64'd9999999999999999999, 1'b1, 6'd19, PAD_ZERO);
        drain_outstanding();
    endtask

    // Random requests: values spread over all bit lengths, signs and extremes
    task automatic test_random(input int n);
        logic [VALUE_W-1:0]  v;
        logic [FWIDTH_W-1:0] w;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: v = {$urandom, $urandom};
                1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: v = 64'($urandom_range(0, 20));
                3: v = -({32'd0, $urandom} >> $urandom_range(0, 31));
                4: v = {$urandom, 1'b1, 31'($urandom)};
                default: begin
                    case ($urandom_range(0, 4))
                        0: v = 64'hFFFF_FFFF_FFFF_FFFF;
                        1: v = 64'h8000_0000_0000_0000;
                        2: v = 64'h7FFF_FFFF_FFFF_FFFF;
                        3: v = 64'd10000000000000000000;
                        default: v = 64'd9999999999999999999;
                    endcase
                end
            endcase
            // mostly around the 32-char limit, now and then well past it
            w = ($urandom_range(0, 9) == 0) ? FWIDTH_W'($urandom_range(33, 63))
                                            : FWIDTH_W'($urandom_range(0, 34));
            offer_conversion(2'($urandom_range(0, 3)), v, 1'($urandom),
                             w, 2'($urandom_range(0, 3)));
        end
        drain_outstanding();
    endtask

    // Receiver holds off while the sender keeps pushing: job queue fills,
    // s_ready must drop, and nothing may be lost when output resumes.
    task automatic test_backpressure();
        source_gaps  = 0;
        hold_request = 1;
        for (int i = 0; i < 8; i++)
            offer_conversion(2'($urandom_range(0, 3)), {$urandom, $urandom}, 1'b1,
                             FWIDTH_W'($urandom_range(0, 34)), 2'($urandom_range(0, 3)));
        drain_outstanding();
    endtask

    // Gap-free tail: back-to-back requests, receiver always ready
    task automatic test_full_rate(input int n);
        source_gaps = 0;
        sink_stalls = 0;
        for (int i = 0; i < n; i++)
            offer_conversion(2'($urandom_range(0, 3)),
                             {$urandom, $urandom} >> $urandom_range(0, 40),
                             1'($urandom), FWIDTH_W'($urandom_range(0, 34)),
                             2'($urandom_range(0, 3)));
        drain_outstanding();
    endtask

    initial begin : main_sequence
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_cmd          <= CMD_SDEC;
        s_value        <= '0;
        s_operand_size <= 1'b0;
        s_field_width  <= '0;
        s_pad_mode     <= PAD_SPACE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        source_gaps = 1;
        sink_stalls = 1;
        test_directed();
        test_random(230);
        test_backpressure();
        test_full_rate(20);

        // let any late stray character show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
